### rtl/dtq_pkg.sv
// Shared types and codes for the deadline timer queue.
// Used by the compare unit, the top level and the checker; depends on nothing.
`default_nettype none

package dtq_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  // request codes
  localparam logic [1:0] REQ_SCHEDULE = 2'd0;
  localparam logic [1:0] REQ_CANCEL   = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  // result status codes
  localparam logic [2:0] ST_SCHEDULED = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] delay_ticks;
    logic [15:0] cancel_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] timer_handle;
    logic        last_result;
  } rsp_t;

  // verdicts of the shared compare unit on the slot under scan
  typedef struct packed {
    logic due;    // slot due time at or before now
    logic first;  // slot leaves before the current best
    logic hit;    // slot handle matches the cancel handle
  } cmp_t;

endpackage

`default_nettype wire

### rtl/dtq_slot_mem.sv
// Slot storage of the timer queue: handle and due time per slot.
// One write port, one read port with registered read data; uses no package.
`default_nettype none

module dtq_slot_mem #(
  parameter int SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
  input  wire logic [15:0]              wr_handle,
  input  wire logic [31:0]              wr_due,
  input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
  output      logic [15:0]              rd_handle,
  output      logic [31:0]              rd_due
);

  logic [15:0] mem_handle [SLOTS];
  logic [31:0] mem_due    [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_handle[wr_addr] <= wr_handle;
      mem_due[wr_addr]    <= wr_due;
    end
    rd_handle <= mem_handle[rd_addr];
    rd_due    <= mem_due[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/dtq_cmp_unit.sv
// Shared compare unit: due check, expiry ordering and handle match for one slot.
// Depends on dtq_pkg for the verdict struct.
`default_nettype none

module dtq_cmp_unit (
  input  wire logic [31:0] now,
  input  wire logic [15:0] next_handle,
  input  wire logic [15:0] cand_handle,
  input  wire logic [31:0] cand_due,
  input  wire logic [15:0] best_handle,
  input  wire logic [31:0] best_due,
  input  wire logic [15:0] want_handle,
  output dtq_pkg::cmp_t    verdict
);

  logic [31:0] late;
  logic [31:0] gap;
  logic [15:0] age_cand;
  logic [15:0] age_best;

  // due times and ages compare modulo their width
  assign late     = now - cand_due;
  assign gap      = cand_due - best_due;
  assign age_cand = next_handle - cand_handle;
  assign age_best = next_handle - best_handle;

  always_comb begin
    verdict.due = ~late[31];
    // equal due and equal age: the earlier slot, already held as best, wins
    if (cand_due != best_due) begin
      verdict.first = gap[31];
    end else begin
      verdict.first = (age_cand > age_best);
    end
    verdict.hit = (cand_handle == want_handle);
  end

endmodule

`default_nettype wire

### rtl/deadline_timer_queue.sv
// Deadline timer queue: schedule presents its result from S_SCHED once the output has space.
// Cancel scans all slots, then answers from S_END.
// Tick: one full slot scan per expired timer plus a closing scan (the S_LAST state
// instead when MAX_RESULTS leave); one memory read a cycle feeds the compare unit.
// One request at a time, a result stall holds the block; req_stall is high until done.
// Reset clears time, handle counter, slot valid bits and output; slot memory is not cleared.
`default_nettype none

module deadline_timer_queue #(
  parameter int TIMER_SLOTS = dtq_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire dtq_pkg::req_t req_word,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall,
  output      dtq_pkg::rsp_t rsp_word
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int NW = $clog2(dtq_pkg::MAX_RESULTS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCHED, S_SCAN, S_DRAIN, S_END, S_LAST
  } state_t;

  state_t             state;
  dtq_pkg::req_t      req_q;
  logic [31:0]        cur_time;
  logic [15:0]        nxt_handle;
  logic [TIMER_SLOTS-1:0] valid;
  logic [IW-1:0]      idx;
  logic               rd_live;
  logic [IW-1:0]      rd_idx;
  logic               best_found;
  logic [IW-1:0]      best_idx;
  logic [15:0]        best_handle;
  logic [31:0]        best_due;
  logic               have_pend;
  logic [15:0]        pend_handle;
  logic [NW-1:0]      n_out;

  logic               space;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic               wr_en;
  logic [15:0]        rd_handle;
  logic [31:0]        rd_due;
  dtq_pkg::cmp_t      verdict;

  assign req_stall = (state != S_IDLE);
  assign space     = ~rsp_valid | ~rsp_stall;
  assign wr_en     = (state == S_SCHED) && space && free_found;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  dtq_slot_mem #(
    .SLOTS(TIMER_SLOTS)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (free_idx),
    .wr_handle(nxt_handle),
    .wr_due   (cur_time + {16'd0, req_q.delay_ticks}),
    .rd_addr  (idx),
    .rd_handle(rd_handle),
    .rd_due   (rd_due)
  );

  dtq_cmp_unit u_cmp (
    .now        (cur_time),
    .next_handle(nxt_handle),
    .cand_handle(rd_handle),
    .cand_due   (rd_due),
    .best_handle(best_handle),
    .best_due   (best_due),
    .want_handle(req_q.cancel_handle),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      cur_time   <= '0;
      nxt_handle <= '0;
      valid      <= '0;
      idx        <= '0;
      rd_live    <= 1'b0;
      best_found <= 1'b0;
      have_pend  <= 1'b0;
      n_out      <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      rd_live <= (state == S_SCAN);
      rd_idx  <= idx;

      // evaluate the slot read last cycle
      if (rd_live && valid[rd_idx]) begin
        if (req_q.req_type == dtq_pkg::REQ_CANCEL) begin
          if (verdict.hit && !best_found) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
          end
        end else if (verdict.due && (!best_found || verdict.first)) begin
          best_found  <= 1'b1;
          best_idx    <= rd_idx;
          best_handle <= rd_handle;
          best_due    <= rd_due;
        end
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q      <= req_word;
            idx        <= '0;
            best_found <= 1'b0;
            case (req_word.req_type)
              dtq_pkg::REQ_SCHEDULE: state <= S_SCHED;
              dtq_pkg::REQ_CANCEL:   state <= S_SCAN;
              dtq_pkg::REQ_TICK: begin
                cur_time  <= cur_time + 32'd1;
                n_out     <= '0;
                have_pend <= 1'b0;
                state     <= S_SCAN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCHED: begin
          if (space) begin
            rsp_valid <= 1'b1;
            if (free_found) begin
              valid[free_idx] <= 1'b1;
              nxt_handle      <= nxt_handle + 16'd1;
              rsp_word        <= '{dtq_pkg::ST_SCHEDULED, nxt_handle, 1'b1};
            end else begin
              rsp_word <= '{dtq_pkg::ST_FULL, 16'd0, 1'b1};
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          idx <= idx + IW'(1);
          if (idx == IW'(TIMER_SLOTS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_END;
        S_END: begin
          if (req_q.req_type == dtq_pkg::REQ_CANCEL) begin
            if (space) begin
              rsp_valid <= 1'b1;
              if (best_found) begin
                valid[best_idx] <= 1'b0;
                rsp_word <= '{dtq_pkg::ST_CANCELLED, req_q.cancel_handle, 1'b1};
              end else begin
                rsp_word <= '{dtq_pkg::ST_NOT_FOUND, req_q.cancel_handle, 1'b1};
              end
              state <= S_IDLE;
            end
          end else if (!have_pend || space) begin
            // the held timer is last when this scan found nothing more
            if (have_pend) begin
              rsp_valid <= 1'b1;
              rsp_word  <= '{dtq_pkg::ST_EXPIRED, pend_handle, ~best_found};
            end
            if (best_found) begin
              valid[best_idx] <= 1'b0;
              pend_handle     <= best_handle;
              have_pend       <= 1'b1;
              n_out           <= n_out + NW'(1);
              idx             <= '0;
              best_found      <= 1'b0;
              if (n_out == NW'(dtq_pkg::MAX_RESULTS - 1)) begin
                state <= S_LAST;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              have_pend <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        S_LAST: begin
          if (space) begin
            rsp_valid <= 1'b1;
            rsp_word  <= '{dtq_pkg::ST_EXPIRED, pend_handle, 1'b1};
            have_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/dtq_checker.sv
// Port-level checker for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg for word types and status codes.
`default_nettype none

module dtq_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire dtq_pkg::rsp_t rsp_word
);

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("result word changed while stalled");

  // schedule and cancel answers are single words
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.status == dtq_pkg::ST_SCHEDULED ||
                  rsp_word.status == dtq_pkg::ST_FULL ||
                  rsp_word.status == dtq_pkg::ST_CANCELLED ||
                  rsp_word.status == dtq_pkg::ST_NOT_FOUND)
    |-> rsp_word.last_result)
    else $error("single-word answer not marked last");

  a_full_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status == dtq_pkg::ST_FULL |-> rsp_word.timer_handle == 16'd0)
    else $error("full status with nonzero handle");

  // leaving reset: idle and nothing on the result side
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !req_stall && !rsp_valid)
    else $error("block not idle after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_word.status <= dtq_pkg::ST_EXPIRED)
    else $error("undefined status code");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk      (clk),
  .rst      (rst),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp_word (rsp_word)
);

`default_nettype wire

### tb/deadline_timer_queue_test.sv
// Self-checking bench for deadline_timer_queue: drives request words, predicts the
// schedule, cancel and tick results from a shadow timer table, checks every response.
// Depends on dtq_pkg and the deadline_timer_queue RTL only.
`default_nettype none

module deadline_timer_queue_test;

  localparam int SLOTS = dtq_pkg::TIMER_SLOTS_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  dtq_pkg::req_t req_word = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  dtq_pkg::rsp_t rsp_word;

  deadline_timer_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow timer table
  logic [31:0] tq_now;
  logic [15:0] tq_next;
  logic        tq_live [SLOTS];
  logic [15:0] tq_handle [SLOTS];
  logic [31:0] tq_due [SLOTS];

  dtq_pkg::req_t req_backlog [$];
  dtq_pkg::rsp_t awaited_results [$];
  bit   req_took = 1'b0;
  int   fault_count = 0;

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic dtq_pkg::rsp_t make_rsp(input logic [2:0] st, input logic [15:0] hnd);
    dtq_pkg::rsp_t r;
    r.status = st;
    r.timer_handle = hnd;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic bit timer_is_due(input int s);
    logic [31:0] d;
    d = tq_now - tq_due[s];
    return !d[31];
  endfunction

  // earlier due time wins, then older handle (modulo age), then lower slot
  function automatic bit leaves_first(input int a, input int b);
    logic [31:0] d;
    logic [15:0] age_a, age_b;
    if (tq_due[a] != tq_due[b]) begin
      d = tq_due[a] - tq_due[b];
      return d[31];
    end
    age_a = tq_next - tq_handle[a];
    age_b = tq_next - tq_handle[b];
    if (age_a != age_b) return age_a > age_b;
    return a < b;
  endfunction

  task automatic predict_timer_results(input dtq_pkg::req_t r);
    dtq_pkg::rsp_t batch [$];
    int s, pick, n;
    pick = -1;
    case (r.req_type)
      dtq_pkg::REQ_SCHEDULE: begin
        for (s = 0; s < SLOTS; s++)
          if (!tq_live[s] && pick < 0) pick = s;
        if (pick < 0) begin
          batch = {batch, make_rsp(dtq_pkg::ST_FULL, 16'h0000)};
        end else begin
          tq_live[pick] = 1'b1;
          tq_handle[pick] = tq_next;
          tq_due[pick] = tq_now + {16'h0000, r.delay_ticks};
          batch = {batch, make_rsp(dtq_pkg::ST_SCHEDULED, tq_next)};
          tq_next = tq_next + 16'd1;
        end
      end
      dtq_pkg::REQ_CANCEL: begin
        for (s = 0; s < SLOTS; s++)
          if (tq_live[s] && tq_handle[s] == r.cancel_handle && pick < 0) pick = s;
        if (pick < 0) begin
          batch = {batch, make_rsp(dtq_pkg::ST_NOT_FOUND, r.cancel_handle)};
        end else begin
          tq_live[pick] = 1'b0;
          batch = {batch, make_rsp(dtq_pkg::ST_CANCELLED, r.cancel_handle)};
        end
      end
      dtq_pkg::REQ_TICK: begin
        tq_now = tq_now + 32'd1;
        for (n = 0; n < dtq_pkg::MAX_RESULTS; n++) begin
          pick = -1;
          for (s = 0; s < SLOTS; s++)
            if (tq_live[s] && timer_is_due(s) && (pick < 0 || leaves_first(s, pick)))
              pick = s;
          if (pick < 0) break;
          tq_live[pick] = 1'b0;
          batch = {batch, make_rsp(dtq_pkg::ST_EXPIRED, tq_handle[pick])};
        end
      end
      default: ;
    endcase
    if (batch.size() != 0) batch[batch.size() - 1].last_result = 1'b1;
    foreach (batch[k]) awaited_results = {awaited_results, batch[k]};
  endtask

  task automatic note_fault(input string what, input dtq_pkg::rsp_t want,
                            input dtq_pkg::rsp_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: expected status %0d handle %h last %b, got status %0d handle %h last %b",
               what, want.status, want.timer_handle, want.last_result,
               got.status, got.timer_handle, got.last_result);
  endtask

  // monitor: take accepted requests into the shadow table, check responses
  always @(posedge clk) begin
    dtq_pkg::rsp_t want;
    req_took = 1'b0;
    if (rst) begin
      tq_now = '0;
      tq_next = '0;
      for (int s = 0; s < SLOTS; s++) tq_live[s] = 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        req_took = 1'b1;
        predict_timer_results(req_word);
      end
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          note_fault("response with none awaited", '0, rsp_word);
        end else begin
          want = awaited_results.pop_front();
          if (rsp_word.status !== want.status || rsp_word.timer_handle !== want.timer_handle ||
              rsp_word.last_result !== want.last_result)
            note_fault("response mismatch", want, rsp_word);
        end
      end
    end
  end

  // driver: bursts of request words with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_took) begin
      // hold the word until it is taken
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      req_valid <= 1'b0;
    end else if (req_backlog.size() != 0) begin
      req_valid <= 1'b1;
      req_word <= req_backlog.pop_front();
      if (burst_left > 1) begin
        burst_left = burst_left - 1;
      end else if ($urandom_range(7) == 0) begin
        burst_left = $urandom_range(60, 20);
        gap_left = 0;
      end else begin
        burst_left = $urandom_range(12, 1);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      end
    end else begin
      req_valid <= 1'b0;
    end
  end

  // response stall: switch between random patterns at random times
  stall_pat_t stall_pat = STALL_NONE;
  int stall_span = 0;

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_pat = stall_pat_t'($urandom_range(3));
        stall_span = $urandom_range(200, 20);
      end else begin
        stall_span = stall_span - 1;
      end
      case (stall_pat)
        STALL_NONE:  rsp_stall <= 1'b0;
        STALL_LIGHT: rsp_stall <= ($urandom_range(3) == 0);
        STALL_HEAVY: rsp_stall <= ($urandom_range(3) != 0);
        default:     rsp_stall <= ~rsp_stall;
      endcase
    end
  end

  task automatic queue_req(input logic [1:0] kind, input logic [15:0] dly,
                           input logic [15:0] hnd);
    dtq_pkg::req_t r;
    while (req_backlog.size() >= 4) @(negedge clk);
    r.req_type = kind;
    r.delay_ticks = dly;
    r.cancel_handle = hnd;
    req_backlog = {req_backlog, r};
  endtask

  task automatic wait_idle();
    while (req_backlog.size() != 0 || req_valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [15:0] dly, hnd;
    logic [15:0] live_h [$];
    int pick, sel;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // empty table: quiet tick, ignored request, cancels that miss
    queue_req(dtq_pkg::REQ_TICK, rnd16(), rnd16());
    queue_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    queue_req(dtq_pkg::REQ_CANCEL, rnd16(), 16'h0000);
    queue_req(dtq_pkg::REQ_CANCEL, rnd16(), 16'hFFFF);
    // equal due times leave oldest first, earlier due time before later
    queue_req(dtq_pkg::REQ_SCHEDULE, 16'd0, rnd16());
    queue_req(dtq_pkg::REQ_SCHEDULE, 16'hFFFF, rnd16());
    queue_req(dtq_pkg::REQ_SCHEDULE, 16'd0, rnd16());
    queue_req(dtq_pkg::REQ_SCHEDULE, 16'd1, rnd16());
    queue_req(dtq_pkg::REQ_SCHEDULE, 16'd1, rnd16());
    queue_req(dtq_pkg::REQ_TICK, rnd16(), rnd16());
    queue_req(dtq_pkg::REQ_CANCEL, rnd16(), 16'd1);
    queue_req(dtq_pkg::REQ_CANCEL, rnd16(), 16'd1);
    // fill the table, overflow it, expire all sixteen in one tick
    repeat (SLOTS) queue_req(dtq_pkg::REQ_SCHEDULE, 16'($urandom_range(1)), rnd16());
    queue_req(dtq_pkg::REQ_SCHEDULE, rnd16(), rnd16());
    queue_req(dtq_pkg::REQ_TICK, rnd16(), rnd16());

    // random mix, short delays so ticks keep expiring timers
    for (int i = 0; i < 170; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        sel = $urandom_range(9);
        if (sel < 6) dly = 16'($urandom_range(12));
        else if (sel < 8) dly = 16'($urandom_range(300));
        else if (sel == 8) dly = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
        else dly = rnd16();
        queue_req(dtq_pkg::REQ_SCHEDULE, dly, rnd16());
      end else if (pick < 62) begin
        live_h.delete();
        for (int s = 0; s < SLOTS; s++)
          if (tq_live[s]) live_h = {live_h, tq_handle[s]};
        if (live_h.size() != 0 && $urandom_range(3) != 0)
          hnd = live_h[$urandom_range(live_h.size() - 1)];
        else if ($urandom_range(1) != 0)
          hnd = rnd16();
        else
          hnd = tq_next - 16'($urandom_range(3, 1));
        queue_req(dtq_pkg::REQ_CANCEL, rnd16(), hnd);
      end else if (pick < 97) begin
        queue_req(dtq_pkg::REQ_TICK, rnd16(), rnd16());
      end else begin
        queue_req(REQ_UNUSED, rnd16(), rnd16());
      end
    end

    wait_idle();
    // let a trailing quiet tick finish its scan
    repeat (400) @(negedge clk);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/dtq_pkg.sv
rtl/dtq_slot_mem.sv
rtl/dtq_cmp_unit.sv
rtl/deadline_timer_queue.sv
rtl/dtq_checker.sv
tb/deadline_timer_queue_test.sv
